// ===== hw/rtl/mandelbrot_escape_time_macros.svh =====
// ----------------------------------------------------------------------------
// Escape-time assertion macros
// Shared concurrent assertion forms for the escape-time block.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// condition implies consequence in the same cycle
`define MET_ASSERT_NOW(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("escape-time assertion failed");

// condition implies consequence in the next cycle
`define MET_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("escape-time assertion failed");

`endif

// ===== hw/rtl/met_pkg.sv =====
// ----------------------------------------------------------------------------
// met_pkg
// Types, constants and helpers of the escape-time block.
// ----------------------------------------------------------------------------
package met_pkg;

  localparam int FRAC_BITS    = 28;
  localparam int Q_W          = FRAC_BITS + 4;
  localparam int MAX_ITER_DEF = 1000;
  localparam int MAX_HEIGHT   = 1024;
  localparam int H_W          = 11;
  localparam int CFG_W        = 32;
  localparam int IDX_W        = 3;
  localparam int DEN_W        = 41;
  localparam int NUM_W        = 44;
  localparam int DIV_STEPS    = FRAC_BITS + 3;
  localparam int SUM_W        = Q_W + 6;

  localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_RE     = 3'd1;
  localparam logic [IDX_W-1:0] REG_CENTER_IM     = 3'd2;
  localparam logic [IDX_W-1:0] REG_ZOOM          = 3'd3;
  localparam logic [IDX_W-1:0] REG_TARGET_X      = 3'd4;
  localparam logic [IDX_W-1:0] REG_TARGET_Y      = 3'd5;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef struct packed {
    logic [10:0] pixel_x;
    logic [9:0]  pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [9:0] iteration_count;
    logic       reached_limit;
  } out_item_t;

  typedef struct packed {
    logic [H_W-1:0]     screen_height;
    logic signed [31:0] center_re;
    logic signed [31:0] center_im;
    logic [30:0]        zoom;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
  } cfg_t;

  typedef struct packed {
    logic signed [Q_W-1:0] cre;
    logic signed [Q_W-1:0] cim;
  } point_t;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > SUM_W'(Q_MAX)) r = Q_MAX;
    else if (v < SUM_W'(Q_MIN)) r = Q_MIN;
    else r = Q_W'(v);
    return r;
  endfunction

endpackage

// ===== hw/rtl/met_front.sv =====
// ----------------------------------------------------------------------------
// met_front
// Maps a pixel to its complex point with a shared serial divider.
// ----------------------------------------------------------------------------
module met_front import met_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     q_push,
  output point_t   q_data
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MAP  = 3'd1;
  localparam logic [2:0] F_LOAD = 3'd2;
  localparam logic [2:0] F_DIV  = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;
  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [2:0]              state;
  in_item_t                pix;
  logic [DEN_W-1:0]        den;
  logic signed [NUM_W-1:0] wx, wy;
  logic                    sel, neg;
  logic [NUM_W:0]          rem;
  logic [DIV_STEPS-1:0]    quo;
  logic [CNT_W-1:0]        cnt;
  logic signed [Q_W-1:0]   cre, cim;

  logic [H_W-1:0]          hs, h34, hh;
  logic [30:0]             zm;
  logic signed [35:0]      nx, ny;
  logic signed [NUM_W-1:0] cx, cy, w, mag;
  logic [NUM_W-1:0]        den8;
  logic [NUM_W:0]          rs, rem_next;
  logic [DIV_STEPS-1:0]    quo_next;
  logic signed [Q_W-1:0]   div_val, sat_val;

  always_comb begin
    if (cfg.screen_height < H_W'(2)) hs = H_W'(2);
    else if (cfg.screen_height > H_W'(MAX_HEIGHT)) hs = H_W'(MAX_HEIGHT);
    else hs = cfg.screen_height;
    zm  = (cfg.zoom == '0) ? 31'd1 : cfg.zoom;
    h34 = H_W'(((H_W+2)'(hs) * (H_W+2)'(3)) >> 2);
    hh  = hs >> 1;
    nx  = $signed({9'b0, pix.pixel_x, 16'b0}) + 36'(cfg.target_x)
          - $signed({9'b0, h34, 16'b0});
    ny  = $signed({10'b0, pix.pixel_y, 16'b0}) + 36'(cfg.target_y)
          - $signed({9'b0, hh, 16'b0});
    cx  = cfg.center_re * $signed({1'b0, hs});
    cy  = cfg.center_im * $signed({1'b0, hs});
    w   = sel ? wy : wx;
    mag = w[NUM_W-1] ? -w : w;
    den8 = {den, 3'b0};
    rs  = {rem[NUM_W-1:0], 1'b0};
    if (rs >= {1'b0, den8}) begin
      rem_next = rs - {1'b0, den8};
      quo_next = {quo[DIV_STEPS-2:0], 1'b1};
    end else begin
      rem_next = rs;
      quo_next = {quo[DIV_STEPS-2:0], 1'b0};
    end
    div_val = neg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
    sat_val = w[NUM_W-1] ? Q_MIN : Q_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      sel   <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push) begin
            pix   <= in_item;
            state <= F_MAP;
          end
        end
        F_MAP: begin
          den   <= DEN_W'(hs) * DEN_W'(zm);
          wx    <= (NUM_W'(nx) <<< 1) - cx;
          wy    <= (NUM_W'(ny) <<< 1) - cy;
          sel   <= 1'b0;
          state <= F_LOAD;
        end
        F_LOAD: begin
          neg <= w[NUM_W-1];
          rem <= {1'b0, mag};
          quo <= '0;
          cnt <= '0;
          if ($unsigned(mag) >= den8) begin
            if (sel) begin
              cim   <= sat_val;
              state <= F_PUSH;
            end else begin
              cre <= sat_val;
              sel <= 1'b1;
            end
          end else begin
            state <= F_DIV;
          end
        end
        F_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            if (sel) begin
              cim   <= div_val;
              state <= F_PUSH;
            end else begin
              cre   <= div_val;
              sel   <= 1'b1;
              state <= F_LOAD;
            end
          end
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign full       = (state != F_IDLE);
  assign q_push     = (state == F_PUSH) && !q_full;
  assign q_data.cre = cre;
  assign q_data.cim = cim;

endmodule

// ===== hw/rtl/met_queue.sv =====
// ----------------------------------------------------------------------------
// met_queue
// Two-entry point queue between the mapping front and the iteration engine.
// ----------------------------------------------------------------------------
module met_queue import met_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  point_t wr_data,
  output logic   full,
  input  logic   rd,
  output point_t rd_data,
  output logic   empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  point_t           mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [PTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + PTR_W'(1);
      if (rd) rptr <= rptr + PTR_W'(1);
      count <= count + (PTR_W+1)'(wr) - (PTR_W+1)'(rd);
    end
  end

  assign rd_data = mem[rptr];
  assign full    = (count == (PTR_W+1)'(DEPTH));
  assign empty   = (count == '0);

endmodule

// ===== hw/rtl/met_back.sv =====
// ----------------------------------------------------------------------------
// met_back
// Iteration engine: z = z*z + c until escape or the limit, one result slot.
// ----------------------------------------------------------------------------
module met_back import met_pkg::*; #(
  parameter int MAX_ITER = MAX_ITER_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  point_t    q_data,
  output logic      q_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_STEP = 2'd2;
  localparam int CNT_W = $clog2(MAX_ITER + 1);
  localparam logic signed [SUM_W-1:0] LIMIT = SUM_W'(4) <<< FRAC_BITS;

  logic [1:0]              state;
  logic signed [Q_W-1:0]   cre, cim, re, im;
  logic signed [2*Q_W-1:0] prr, pii, pri;
  logic [CNT_W-1:0]        cnt;
  logic                    out_valid;
  out_item_t               result;

  logic signed [SUM_W-1:0] re2, im2, ri, nre, nim;
  logic [2*Q_W-1:0]        ri_mag;
  logic                    more, deliver;

  always_comb begin
    re2    = SUM_W'(prr >>> FRAC_BITS);
    im2    = SUM_W'(pii >>> FRAC_BITS);
    ri_mag = pri[2*Q_W-1] ? $unsigned(-pri) : $unsigned(pri);
    ri     = $signed(SUM_W'(ri_mag >> (FRAC_BITS - 1)));
    if (pri[2*Q_W-1]) ri = -ri;
    nre    = re2 - im2 + SUM_W'(cre);
    nim    = ri + SUM_W'(cim);
    more   = (cnt < CNT_W'(MAX_ITER)) && ((re2 + im2) < LIMIT);
    deliver = (state == B_STEP) && !more && (!out_valid || pop);
  end

  assign q_pop = (state == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (deliver) begin
        out_valid              <= 1'b1;
        result.iteration_count <= 10'(cnt);
        result.reached_limit   <= (cnt == CNT_W'(MAX_ITER));
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cre   <= q_data.cre;
            cim   <= q_data.cim;
            re    <= q_data.cre;
            im    <= q_data.cim;
            cnt   <= '0;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          prr   <= re * re;
          pii   <= im * im;
          pri   <= re * im;
          state <= B_STEP;
        end
        B_STEP: begin
          if (more) begin
            re    <= sat_q(nre);
            im    <= sat_q(nim);
            cnt   <= cnt + CNT_W'(1);
            state <= B_MUL;
          end else if (deliver) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign empty    = !out_valid;
  assign out_item = result;

endmodule

// ===== hw/rtl/mandelbrot_escape_time.sv =====
// Flow: the front maps a pixel with at most one serial divide per axis,
// then the engine runs its escape iterations and hands off the result.
// The front takes a new pixel once the last one is queued; the iteration
// engine's square-and-add loop sets the rate for points near the set.
// Reset (rst, synchronous): registers return to their reset values and
// the queue, engine and result slot are emptied.
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time evaluator: pixel mapping front, point queue, iteration engine.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_macros.svh"

module mandelbrot_escape_time import met_pkg::*; #(
  parameter int MAX_ITER = MAX_ITER_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             push,
  output logic             full,
  input  in_item_t         in_item,
  input  logic             pop,
  output logic             empty,
  output out_item_t        out_item
);

  cfg_t   cfg;
  logic   q_full, q_empty, q_push, q_pop;
  point_t q_wr_data, q_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_height <= H_W'(512);
      cfg.center_re     <= '0;
      cfg.center_im     <= '0;
      cfg.zoom          <= 31'd65536;
      cfg.target_x      <= '0;
      cfg.target_y      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[H_W-1:0];
        REG_CENTER_RE:     cfg.center_re     <= $signed(cfg_data);
        REG_CENTER_IM:     cfg.center_im     <= $signed(cfg_data);
        REG_ZOOM:          cfg.zoom          <= cfg_data[30:0];
        REG_TARGET_X:      cfg.target_x      <= $signed(cfg_data);
        REG_TARGET_Y:      cfg.target_y      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  met_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wr_data)
  );

  met_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  met_back #(
    .MAX_ITER (MAX_ITER)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_rd_data),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

  `MET_ASSERT_NEXT(a_front_busy, push && !full, full)
  `MET_ASSERT_NOW(a_limit_count, !empty && out_item.reached_limit, out_item.iteration_count == 10'(MAX_ITER))
  `MET_ASSERT_NOW(a_queue_write, q_push, !q_full)

endmodule

// ===== bench/tb_mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// Escape-time evaluator testbench
// Drives pixels through the queue-style input under several view settings.
// An internal fixed-point model predicts the iteration count and limit flag
// of each pixel not given a known result; results are checked in order.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time;
  timeunit 1ns;
  timeprecision 1ps;
  import met_pkg::*;

  localparam int ITER_LIMIT = 1000;
  localparam int STALL_LIMIT = 60000;
  localparam int PHASE_ITEMS = 60;
  localparam int PHASES = 10;
  localparam longint QHI = (64'sd1 <<< (FRAC_BITS + 3)) - 1;
  localparam longint QLO = -(64'sd1 <<< (FRAC_BITS + 3));

  typedef struct {
    int px;
    int py;
    bit known;
    out_item_t res;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  in_item_t in_item = '0;
  logic pop = 1'b0;
  logic empty;
  out_item_t out_item;

  cfg_t view;
  out_item_t pending_counts[$];
  int mismatches = 0;
  int checked = 0;
  int sent = 0;
  int settings = 0;
  int in_set = 0;
  int idle_cycles = 0;
  int burst_left = 1;
  int rx_mode = 0;
  int rx_cycle = 0;

  mandelbrot_escape_time uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .push(push), .full(full), .in_item(in_item),
    .pop(pop), .empty(empty), .out_item(out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint sq_mul(longint a, longint b, int sh);
    bit [63:0] ua;
    bit [63:0] ub;
    bit [63:0] prod;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    prod = (ua * ub) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic longint to_fixed(longint w, bit [63:0] d);
    bit [127:0] num;
    bit [127:0] q;
    bit [63:0] uw;
    uw = (w < 0) ? -w : w;
    if (uw / d >= 8) return (w < 0) ? QLO : QHI;
    num = {64'd0, uw} << FRAC_BITS;
    q = num / d;
    return (w < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint clamp_q(longint v);
    if (v > QHI) return QHI;
    if (v < QLO) return QLO;
    return v;
  endfunction

  function automatic out_item_t escape_count(in_item_t pix);
    longint h, zm, nx, ny, cr, ci, re, im, re2, im2, nre;
    int n;
    out_item_t r;
    h = view.screen_height;
    zm = view.zoom;
    if (zm == 0) zm = 1;
    if (h < 2) h = 2;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    nx = longint'(pix.pixel_x) * 65536 + longint'(view.target_x) - (h * 3 / 4) * 65536;
    ny = longint'(pix.pixel_y) * 65536 + longint'(view.target_y) - (h / 2) * 65536;
    cr = to_fixed(2 * nx - longint'(view.center_re) * h, h * zm);
    ci = to_fixed(2 * ny - longint'(view.center_im) * h, h * zm);
    re = cr;
    im = ci;
    re2 = sq_mul(re, re, FRAC_BITS);
    im2 = sq_mul(im, im, FRAC_BITS);
    n = 0;
    while (n < ITER_LIMIT && re2 + im2 < (64'sd4 <<< FRAC_BITS)) begin
      nre = clamp_q(re2 - im2 + cr);
      im = clamp_q(sq_mul(re, im, FRAC_BITS - 1) + ci);
      re = nre;
      re2 = sq_mul(re, re, FRAC_BITS);
      im2 = sq_mul(im, im, FRAC_BITS);
      n++;
    end
    r.iteration_count = n[9:0];
    r.reached_limit = (n == ITER_LIMIT);
    return r;
  endfunction

  task automatic set_view(int h, int cre, int cim, int zm, int tx, int ty);
    logic [CFG_W-1:0] vals[6];
    logic [IDX_W-1:0] idx[6];
    vals = '{h, cre, cim, zm, tx, ty};
    idx = '{REG_SCREEN_HEIGHT, REG_CENTER_RE, REG_CENTER_IM, REG_ZOOM,
            REG_TARGET_X, REG_TARGET_Y};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    view.screen_height = vals[0][H_W-1:0];
    view.center_re = vals[1];
    view.center_im = vals[2];
    view.zoom = vals[3][30:0];
    view.target_x = vals[4];
    view.target_y = vals[5];
    settings++;
    @(posedge clk);
  endtask

  task automatic send_pixel(int px, int py, bit known, out_item_t res);
    in_item_t pix;
    out_item_t exp_res;
    pix.pixel_x = px[10:0];
    pix.pixel_y = py[9:0];
    exp_res = known ? res : escape_count(pix);
    in_item <= pix;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_counts.push_back(exp_res);
    sent++;
    if (exp_res.reached_limit) in_set++;
    burst_left--;
    if (burst_left <= 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 300 == 0) rx_mode <= $urandom_range(0, 2);
    if (rst) begin
      pop <= 1'b0;
    end else begin
      case (rx_mode)
        0: pop <= 1'b1;
        1: pop <= $urandom_range(0, 1);
        default: pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%0b",
          out_item.iteration_count, out_item.reached_limit);
      end else begin
        out_item_t e;
        e = pending_counts.pop_front();
        checked++;
        if (out_item.iteration_count !== e.iteration_count ||
            out_item.reached_limit !== e.reached_limit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: count exp %0d got %0d, limit exp %0b got %0b",
              checked, e.iteration_count, out_item.iteration_count,
              e.reached_limit, out_item.reached_limit);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pixel_row_t rows[$];
    int h, px, py, kind;
    out_item_t none;
    none = '0;
    view = '{screen_height: 512, center_re: 0, center_im: 0, zoom: 65536,
             target_x: 0, target_y: 0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows = '{
      '{0, 0, 1'b1, '{10'd1, 1'b0}},
      '{384, 256, 1'b1, '{10'd1000, 1'b1}},
      '{2047, 1023, 1'b0, '0},
      '{1535, 1023, 1'b0, '0},
      '{0, 1023, 1'b0, '0},
      '{2047, 0, 1'b0, '0},
      '{1365, 682, 1'b0, '0},
      '{682, 341, 1'b0, '0},
      '{300, 200, 1'b0, '0},
      '{100, 256, 1'b0, '0},
      '{400, 300, 1'b0, '0},
      '{250, 180, 1'b0, '0}
    };
    foreach (rows[i]) send_pixel(rows[i].px, rows[i].py, rows[i].known, rows[i].res);
    drain();

    set_view(0, 32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff);
    send_pixel(0, 0, 1'b0, none);
    send_pixel(2047, 1023, 1'b0, none);
    drain();
    set_view(2047, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_pixel(0, 0, 1'b0, none);
    send_pixel(2047, 1023, 1'b0, none);
    drain();
    set_view(2, 0, 0, 65536, 0, 0);
    for (int i = 0; i < 4; i++) send_pixel(i % 3, i / 2, 1'b0, none);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      kind = p % 4;
      case (kind)
        0: set_view($urandom_range(2, 1024), $urandom_range(0, 4 * 65536) - 2 * 65536,
                    $urandom_range(0, 4 * 65536) - 2 * 65536,
                    $urandom_range(32768, 4 * 65536),
                    $urandom_range(0, 400 * 65536) - 200 * 65536,
                    $urandom_range(0, 400 * 65536) - 200 * 65536);
        1: set_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        2: set_view(($urandom_range(0, 1) ? 2047 : 0), ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000),
                    ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000),
                    ($urandom_range(0, 1) ? 32'h7fffffff : 0),
                    $urandom, $urandom);
        default: set_view($urandom_range(64, 256), -49152, $urandom_range(0, 32768) - 16384,
                          $urandom_range(4 * 65536, 64 * 65536), 0, 0);
      endcase
      h = view.screen_height < 2 ? 2 : (view.screen_height > 1024 ? 1024 : view.screen_height);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          px = $urandom_range(0, 2047);
          py = $urandom_range(0, 1023);
        end else begin
          px = $urandom_range(0, h * 3 / 2 - 1);
          py = $urandom_range(0, h - 1);
        end
        send_pixel(px, py, 1'b0, none);
      end
      drain();
    end

    $display("%0d pixels over %0d view settings, %0d results checked, %0d in the set",
             sent, settings, checked, in_set);
    if (mismatches == 0 && pending_counts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end
endmodule
